// File: sv/dsc_pkg.sv
`timescale 1ns / 1ps

package dsc_pkg;

  localparam int TAPS              = 8;
  localparam int TAP_IDX_W         = $clog2(TAPS);
  localparam int PIX_W             = 8;
  localparam int PROD_W            = 16;
  localparam int ACC_W             = 20;
  localparam int FILT_SHIFT        = 7;
  localparam int SIZE_W            = 12;
  localparam int TAPS_W            = TAPS * PIX_W;
  localparam int MAX_OUT_WIDTH_DEF = 2048;
  localparam int MAX_OUT_HEIGHT    = 2048;
  localparam int OUT_FIFO_DEPTH    = 16;
  localparam int REG_IDX_W         = 2;

  localparam logic [REG_IDX_W-1:0] REG_TAPS   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_item_t;

  // signed tap times unsigned pixel; the product always fits 16 bits
  function automatic prod_t tap_mul(input logic [PIX_W-1:0] tap, input logic [PIX_W-1:0] pix);
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] b;
    a = {{(PROD_W-PIX_W){tap[PIX_W-1]}}, tap};
    b = {{(PROD_W-PIX_W){1'b0}}, pix};
    return a * b;
  endfunction

  // round already added; drop negatives to 0, saturate at 255
  function automatic logic [PIX_W-1:0] clip8(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (acc[ACC_W-2:FILT_SHIFT+PIX_W] != '0) begin
      res = '1;
    end else begin
      res = acc[FILT_SHIFT+PIX_W-1:FILT_SHIFT];
    end
    return res;
  endfunction

endpackage

// File: sv/dsc_tap_cell.sv
`timescale 1ns / 1ps

module dsc_tap_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [dsc_pkg::PIX_W-1:0]   tap,
  input  logic [dsc_pkg::PIX_W-1:0]   din,
  output logic [dsc_pkg::PIX_W-1:0]   pix,
  output dsc_pkg::prod_t              prod
);

  // hold one window pixel, pass it to the left neighbor on every request
  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (en) begin
      pix <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= dsc_pkg::tap_mul(tap, din);
    end
  end

endmodule

// File: sv/dsc_vcell.sv
`timescale 1ns / 1ps

module dsc_vcell #(
  parameter int DEPTH = dsc_pkg::MAX_OUT_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        re,
  input  logic                        we,
  input  logic [AW-1:0]               addr,
  input  logic [dsc_pkg::PIX_W-1:0]   wdata,
  input  logic                        sel_cur,
  input  logic [dsc_pkg::PIX_W-1:0]   cur,
  input  logic [dsc_pkg::PIX_W-1:0]   tap,
  output dsc_pkg::prod_t              prod
);

  logic [dsc_pkg::PIX_W-1:0] mem [DEPTH];
  logic [dsc_pkg::PIX_W-1:0] rdata;

  // one line of horizontal results; read returns the old entry on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

  // the line being written this row takes the fresh value instead of the store
  always_ff @(posedge clk) begin
    prod <= dsc_pkg::tap_mul(tap, sel_cur ? cur : rdata);
  end

endmodule

// File: sv/dsc_tap_sum.sv
`timescale 1ns / 1ps

module dsc_tap_sum (
  input  logic                        clk,
  input  dsc_pkg::prod_t              prod [dsc_pkg::TAPS],
  output logic [dsc_pkg::PIX_W-1:0]   result
);

  localparam int S1_W = dsc_pkg::PROD_W + 1;
  localparam int S2_W = dsc_pkg::PROD_W + 2;

  logic signed [S1_W-1:0]          s1 [4];
  logic signed [S2_W-1:0]          s2 [2];
  logic signed [dsc_pkg::ACC_W-1:0] total;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s1[i] <= {prod[2*i][dsc_pkg::PROD_W-1], prod[2*i]}
             + {prod[2*i+1][dsc_pkg::PROD_W-1], prod[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s2[i] <= {s1[2*i][S1_W-1], s1[2*i]} + {s1[2*i+1][S1_W-1], s1[2*i+1]};
    end
  end

  always_comb begin
    total = {{(dsc_pkg::ACC_W-S2_W){s2[0][S2_W-1]}}, s2[0]}
          + {{(dsc_pkg::ACC_W-S2_W){s2[1][S2_W-1]}}, s2[1]}
          + dsc_pkg::ACC_W'(1 << (dsc_pkg::FILT_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    result <= dsc_pkg::clip8(total);
  end

endmodule

// File: sv/dsc_out_fifo.sv
`timescale 1ns / 1ps

module dsc_out_fifo #(
  parameter int DEPTH = dsc_pkg::OUT_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dsc_pkg::out_item_t    din,
  input  logic                  pop,
  output logic                  valid,
  output dsc_pkg::out_item_t    dout
);

  localparam int PW = $clog2(DEPTH);

  dsc_pkg::out_item_t mem [DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        count;

  // room is reserved upstream before a request is taken, so push never overflows
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

endmodule

// File: sv/downscale_2to1_8tap_separable.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload               Carries
// input    in_valid, in_stall     src_pixel             source pixels, raster order
// output   out_valid, out_stall   out_pixel, frame_end  filtered pixels, last-of-frame flag
// config   cfg_valid, cfg_ready   cfg_index, cfg_data   taps, width, height writes
//
// One source pixel per clock while in_stall is low. A request enters a chain of eight tap
// cells; the products pass an adder tree into a registered horizontal sum, written into
// eight line-bank cells (one per source row mod 8) at column x on the next edge, and the
// vertical sum enters the output queue. Reset is synchronous and clears counters, window and
// queue; the line banks are not cleared. in_stall rises only when the 16-entry output queue
// plus results in flight would overflow, so it never follows out_stall within the same cycle.

module downscale_2to1_8tap_separable #(
  parameter int MAX_OUT_WIDTH = dsc_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dsc_pkg::PIX_W-1:0]          src_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dsc_pkg::PIX_W-1:0]          out_pixel,
  output logic                               frame_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dsc_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [dsc_pkg::TAPS_W-1:0]         cfg_data
);

  localparam int TAPS = dsc_pkg::TAPS;
  localparam int PW   = dsc_pkg::PIX_W;
  localparam int BW   = dsc_pkg::TAP_IDX_W;
  localparam int AW   = $clog2(MAX_OUT_WIDTH);
  localparam int WW   = $clog2(MAX_OUT_WIDTH + 1);
  localparam int HW   = $clog2(dsc_pkg::MAX_OUT_HEIGHT + 1);
  localparam int CW   = $clog2(2 * MAX_OUT_WIDTH + TAPS);
  localparam int RW   = $clog2(2 * dsc_pkg::MAX_OUT_HEIGHT + TAPS);
  localparam int QD   = dsc_pkg::OUT_FIFO_DEPTH;
  localparam int QW   = $clog2(QD + 1);
  localparam int HLAT = 4;
  localparam int VLAT = 4;

  // configuration registers
  logic [dsc_pkg::TAPS_W-1:0] filter_taps;
  logic [dsc_pkg::SIZE_W-1:0] out_width;
  logic [dsc_pkg::SIZE_W-1:0] out_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_taps <= '0;
      out_width   <= dsc_pkg::SIZE_W'(1);
      out_height  <= dsc_pkg::SIZE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dsc_pkg::REG_TAPS:   filter_taps <= cfg_data;
        dsc_pkg::REG_WIDTH:  out_width   <= cfg_data[dsc_pkg::SIZE_W-1:0];
        dsc_pkg::REG_HEIGHT: out_height  <= cfg_data[dsc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (out_width == '0) begin
      w_eff = WW'(1);
    end else if ((dsc_pkg::SIZE_W+1)'(out_width) > (dsc_pkg::SIZE_W+1)'(MAX_OUT_WIDTH)) begin
      w_eff = WW'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WW'(out_width);
    end
    if (out_height == '0) begin
      h_eff = HW'(1);
    end else if ((dsc_pkg::SIZE_W+1)'(out_height)
                 > (dsc_pkg::SIZE_W+1)'(dsc_pkg::MAX_OUT_HEIGHT)) begin
      h_eff = HW'(dsc_pkg::MAX_OUT_HEIGHT);
    end else begin
      h_eff = HW'(out_height);
    end
  end

  // frame position
  logic          accept;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [CW:0]   src_w;
  logic [RW:0]   src_h;
  logic [CW-1:0] x_full;
  logic [RW-1:0] y_full;
  logic          h_go;
  logic          v_go;
  logic          last_px;

  assign accept  = in_valid && !in_stall;
  assign col_inc = (CW+1)'(col_count) + 1'b1;
  assign row_inc = (RW+1)'(row_count) + 1'b1;
  assign src_w   = (CW+1)'({w_eff, 1'b0}) + (CW+1)'(TAPS - 2);
  assign src_h   = (RW+1)'({h_eff, 1'b0}) + (RW+1)'(TAPS - 2);
  assign x_full  = (col_count - CW'(TAPS - 1)) >> 1;
  assign y_full  = (row_count - RW'(TAPS - 1)) >> 1;
  assign h_go    = (col_count >= CW'(TAPS - 1)) && col_count[0] && (x_full < CW'(w_eff));
  assign v_go    = (row_count >= RW'(TAPS - 1)) && row_count[0] && (y_full < RW'(h_eff));
  assign last_px = (x_full == CW'(w_eff) - 1'b1) && (y_full == RW'(h_eff) - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_inc >= src_w) begin
        col_count <= '0;
        row_count <= (row_inc >= src_h) ? '0 : row_inc[RW-1:0];
      end else begin
        col_count <= col_inc[CW-1:0];
      end
    end
  end

  // horizontal chain: cell k holds window pixel k, the newest enters cell TAPS-1
  logic [PW-1:0]  hpix  [TAPS];
  dsc_pkg::prod_t hprod [TAPS];

  for (genvar k = 0; k < TAPS; k++) begin : g_hcell
    logic [PW-1:0] din;
    if (k == TAPS - 1) begin : g_head
      assign din = src_pixel;
    end else begin : g_link
      assign din = hpix[k+1];
    end
    dsc_tap_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (accept),
      .tap  (filter_taps[k*PW +: PW]),
      .din  (din),
      .pix  (hpix[k]),
      .prod (hprod[k])
    );
  end

  logic [PW-1:0] hv;

  dsc_tap_sum u_hsum (
    .clk    (clk),
    .prod   (hprod),
    .result (hv)
  );

  // control that travels with the horizontal sum
  logic [HLAT-1:0] h_valid;
  logic [HLAT-1:0] h_vgo;
  logic [HLAT-1:0] h_last;
  logic [AW-1:0]   h_x    [HLAT];
  logic [BW-1:0]   h_bank [HLAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= '0;
    end else begin
      h_valid <= {h_valid[HLAT-2:0], accept && h_go};
    end
  end

  always_ff @(posedge clk) begin
    h_vgo  <= {h_vgo[HLAT-2:0], v_go};
    h_last <= {h_last[HLAT-2:0], last_px};
    h_x[0]    <= x_full[AW-1:0];
    h_bank[0] <= row_count[BW-1:0];
    for (int s = 1; s < HLAT; s++) begin
      h_x[s]    <= h_x[s-1];
      h_bank[s] <= h_bank[s-1];
    end
  end

  // stage at the line banks
  logic          m_valid;
  logic          m_last;
  logic [BW-1:0] m_bank;
  logic [PW-1:0] m_hv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= h_valid[HLAT-1] && h_vgo[HLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    m_last <= h_last[HLAT-1];
    m_bank <= h_bank[HLAT-1];
    m_hv   <= hv;
  end

  // vertical cells: bank j holds rows with row mod 8 == j; tap index rotates with the row
  dsc_pkg::prod_t vprod [TAPS];

  for (genvar j = 0; j < TAPS; j++) begin : g_vcell
    logic [BW-1:0] tap_sel;
    assign tap_sel = BW'(j) + BW'(TAPS - 1) - m_bank;
    dsc_vcell #(
      .DEPTH (MAX_OUT_WIDTH),
      .AW    (AW)
    ) u_cell (
      .clk     (clk),
      .re      (h_valid[HLAT-1]),
      .we      (h_valid[HLAT-1] && (h_bank[HLAT-1] == BW'(j))),
      .addr    (h_x[HLAT-1]),
      .wdata   (hv),
      .sel_cur (m_bank == BW'(j)),
      .cur     (m_hv),
      .tap     (filter_taps[tap_sel*PW +: PW]),
      .prod    (vprod[j])
    );
  end

  logic [PW-1:0] vres;

  dsc_tap_sum u_vsum (
    .clk    (clk),
    .prod   (vprod),
    .result (vres)
  );

  logic [VLAT-1:0] v_valid;
  logic [VLAT-1:0] v_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= '0;
    end else begin
      v_valid <= {v_valid[VLAT-2:0], m_valid};
    end
  end

  always_ff @(posedge clk) begin
    v_last <= {v_last[VLAT-2:0], m_last};
  end

  // output queue and credit for results in flight
  dsc_pkg::out_item_t q_in;
  dsc_pkg::out_item_t q_out;
  logic               pop;
  logic [QW-1:0]      reserved;
  logic               take;

  assign q_in.pixel = vres;
  assign q_in.last  = v_last[VLAT-1];
  assign pop        = out_valid && !out_stall;
  assign take       = accept && h_go && v_go;

  dsc_out_fifo #(
    .DEPTH (QD)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (v_valid[VLAT-1]),
    .din   (q_in),
    .pop   (pop),
    .valid (out_valid),
    .dout  (q_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if (take && !pop) begin
      reserved <= reserved + 1'b1;
    end else if (!take && pop) begin
      reserved <= reserved - 1'b1;
    end
  end

  assign in_stall  = (reserved >= QW'(QD));
  assign out_pixel = q_out.pixel;
  assign frame_end = q_out.last;

endmodule
